>>> hw/rtl/dgcd_pkg.sv
// ============================================================================
// dgcd_pkg
// Shared types and constants of the directed graph cycle detector: vertex
// and count widths, action, status and register codes, controller states.
// ============================================================================
package dgcd_pkg;

  // Graph size and derived widths
  localparam int unsigned MaxVertices = 64;
  localparam int unsigned VtxW        = $clog2(MaxVertices);
  localparam int unsigned CntW        = $clog2(MaxVertices + 1);

  // Fixed field widths of the ports
  localparam int unsigned FieldVtxW = 6;
  localparam int unsigned CfgW      = 7;
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutDataW  = 8;

  typedef logic [MaxVertices-1:0] row_t;
  typedef logic [VtxW-1:0]        vtx_t;
  typedef logic [CntW-1:0]        cnt_t;

  typedef enum logic [1:0] {
    ActAddEdge = 2'd0,
    ActCheck   = 2'd1,
    ActClear   = 2'd2,
    ActNone    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StEdgeStored = 2'd0,
    StCheckDone  = 2'd1,
    StCleared    = 2'd2,
    StRangeErr   = 2'd3
  } status_e;

  typedef enum logic {
    CfgVertexCount = 1'b0,
    CfgMirrorEdges = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    SIdle,
    SAddWr1,
    SAddRd2,
    SAddWr2,
    SCkRoot,
    SCkLoad,
    SCkStep,
    SCkPop,
    SResp
  } state_e;

  // One entry of the walk stack: vertex and next neighbor index to scan
  typedef struct packed {
    cnt_t idx;
    vtx_t vtx;
  } stack_entry_t;

endpackage

>>> hw/rtl/directed_graph_cycle_detect_unit.sv
// ============================================================================
// directed_graph_cycle_detect_unit
// Adjacency bit matrix in a synchronous memory, loaded one edge per item,
// with an iterative depth-first cycle check driven by a walk stack memory.
// ============================================================================
// One item is taken at a time; each returns one result through an output
// register, and the next item is taken while that result waits. Clear and
// invalid items go straight to their result; add edge reads the source row
// and writes it back with the new bit (in mirror mode it then reads and
// writes a second row). A check item is paced by the adjacency memory read
// port: each root vertex tried, each vertex entered (row fetch, then the
// scan that finds no neighbor left), each edge scanned and each backtrack
// that returns to a stacked vertex (stack read, then row fetch) is a step of
// its own, and the result is handed over last. Clearing the graph needs no
// clearing pass: a valid bit per row, dropped by reset or a clear item,
// makes an unwritten row read as empty.
module directed_graph_cycle_detect_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [dgcd_pkg::CfgW-1:0]     cfg_wdata_i,
  // Input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [dgcd_pkg::InDataW-1:0]  s_axis_tdata,   // from_vertex[5:0], to_vertex[11:6]
  input  logic [1:0]                    s_axis_tuser,   // action[1:0]
  // Result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [dgcd_pkg::OutDataW-1:0] m_axis_tdata,   // cycle_found[0]
  output logic [1:0]                    m_axis_tuser    // status[1:0]
);

  localparam int unsigned MaxV = dgcd_pkg::MaxVertices;
  localparam int unsigned VtxW = dgcd_pkg::VtxW;
  localparam int unsigned CntW = dgcd_pkg::CntW;

  // Controller state
  dgcd_pkg::state_e state_q, state_d;

  // Configuration
  dgcd_pkg::cnt_t   n_q, n_d;
  dgcd_pkg::row_t   keep_q, keep_d;
  logic             mirror_q, mirror_d;

  // Graph bookkeeping
  dgcd_pkg::row_t   row_valid_q, row_valid_d;
  dgcd_pkg::vtx_t   from_q, from_d;
  dgcd_pkg::vtx_t   to_q, to_d;

  // Walk state
  dgcd_pkg::row_t   visited_q, visited_d;
  dgcd_pkg::row_t   onpath_q, onpath_d;
  dgcd_pkg::cnt_t   root_q, root_d;
  dgcd_pkg::cnt_t   sp_q, sp_d;
  dgcd_pkg::vtx_t   top_vtx_q, top_vtx_d;
  dgcd_pkg::cnt_t   top_idx_q, top_idx_d;
  dgcd_pkg::row_t   row_q, row_d;

  // Result holding and output register
  logic             res_found_q, res_found_d;
  dgcd_pkg::status_e res_status_q, res_status_d;
  logic             out_valid_q, out_valid_d;
  logic             out_found_q, out_found_d;
  dgcd_pkg::status_e out_status_q, out_status_d;

  // Adjacency memory
  dgcd_pkg::row_t   adj_mem [MaxV];
  dgcd_pkg::row_t   adj_rdata_q;
  logic             adj_rvalid_q;
  logic             adj_re, adj_we;
  dgcd_pkg::vtx_t   adj_raddr, adj_waddr;
  dgcd_pkg::row_t   adj_wdata;

  // Walk stack memory, holds every entry below the top of stack
  dgcd_pkg::stack_entry_t stk_mem [MaxV];
  dgcd_pkg::stack_entry_t stk_rdata_q;
  logic                   stk_re, stk_we;
  dgcd_pkg::vtx_t         stk_raddr, stk_waddr;
  dgcd_pkg::stack_entry_t stk_wdata;

  // Input decode
  logic                       s_accept;
  dgcd_pkg::action_e          s_action;
  logic [dgcd_pkg::FieldVtxW-1:0] s_from, s_to;
  logic                       s_out_of_range;

  // Neighbor search
  dgcd_pkg::row_t   hi_mask, search, lowest;
  logic             nb_found;
  dgcd_pkg::vtx_t   nb_j;
  dgcd_pkg::cnt_t   nb_next_idx;
  logic             out_load;
  dgcd_pkg::row_t   cur_row;

  // Effective vertex count of a config write
  dgcd_pkg::cnt_t   cfg_n;

  assign s_accept       = s_axis_tvalid && s_axis_tready;
  assign s_action       = dgcd_pkg::action_e'(s_axis_tuser);
  assign s_from         = s_axis_tdata[dgcd_pkg::FieldVtxW-1:0];
  assign s_to           = s_axis_tdata[2*dgcd_pkg::FieldVtxW-1:dgcd_pkg::FieldVtxW];
  assign s_out_of_range = (32'(s_from) >= 32'(n_q)) || (32'(s_to) >= 32'(n_q));

  assign s_axis_tready = (state_q == dgcd_pkg::SIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = dgcd_pkg::OutDataW'(out_found_q);
  assign m_axis_tuser  = out_status_q;

  // Take the output slot when it is empty or being drained
  assign out_load = (state_q == dgcd_pkg::SResp) && (!out_valid_q || m_axis_tready);

  // Row as read from memory, empty when never written since the last clear
  assign cur_row = adj_rvalid_q ? adj_rdata_q : '0;

  // Saturate a written vertex count to 1..MaxVertices
  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_n = CntW'(1);
    end else if (32'(cfg_wdata_i) > MaxV) begin
      cfg_n = CntW'(MaxV);
    end else begin
      cfg_n = CntW'(cfg_wdata_i);
    end
  end

  // Find the lowest neighbor at or above the scan index
  always_comb begin
    for (int i = 0; i < MaxV; i++) begin
      hi_mask[i] = (32'(i) >= 32'(top_idx_q));
    end
    search   = row_q & hi_mask;
    lowest   = search & (~search + dgcd_pkg::row_t'(1));
    nb_found = |search;
    nb_j     = '0;
    for (int i = 0; i < MaxV; i++) begin
      if (lowest[i]) begin
        nb_j = nb_j | VtxW'(i);
      end
    end
    nb_next_idx = CntW'(nb_j) + CntW'(1);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dgcd_pkg::SIdle: begin
        if (s_accept) begin
          case (s_action)
            dgcd_pkg::ActAddEdge: state_d = s_out_of_range ? dgcd_pkg::SResp : dgcd_pkg::SAddWr1;
            dgcd_pkg::ActCheck:   state_d = dgcd_pkg::SCkRoot;
            default:              state_d = dgcd_pkg::SResp;
          endcase
        end
      end
      dgcd_pkg::SAddWr1: state_d = mirror_q ? dgcd_pkg::SAddRd2 : dgcd_pkg::SResp;
      dgcd_pkg::SAddRd2: state_d = dgcd_pkg::SAddWr2;
      dgcd_pkg::SAddWr2: state_d = dgcd_pkg::SResp;
      dgcd_pkg::SCkRoot: begin
        if (root_q >= n_q) begin
          state_d = dgcd_pkg::SResp;
        end else if (!visited_q[root_q[VtxW-1:0]]) begin
          state_d = dgcd_pkg::SCkLoad;
        end
      end
      dgcd_pkg::SCkLoad: state_d = dgcd_pkg::SCkStep;
      dgcd_pkg::SCkStep: begin
        if (!nb_found) begin
          state_d = (sp_q == CntW'(1)) ? dgcd_pkg::SCkRoot : dgcd_pkg::SCkPop;
        end else if (!visited_q[nb_j]) begin
          if (32'(sp_q) < MaxV) begin
            state_d = dgcd_pkg::SCkLoad;
          end
        end else if (onpath_q[nb_j]) begin
          state_d = dgcd_pkg::SResp;
        end
      end
      dgcd_pkg::SCkPop: state_d = dgcd_pkg::SCkLoad;
      dgcd_pkg::SResp: begin
        if (out_load) begin
          state_d = dgcd_pkg::SIdle;
        end
      end
      default: state_d = dgcd_pkg::SIdle;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    n_d          = n_q;
    keep_d       = keep_q;
    mirror_d     = mirror_q;
    row_valid_d  = row_valid_q;
    from_d       = from_q;
    to_d         = to_q;
    visited_d    = visited_q;
    onpath_d     = onpath_q;
    root_d       = root_q;
    sp_d         = sp_q;
    top_vtx_d    = top_vtx_q;
    top_idx_d    = top_idx_q;
    row_d        = row_q;
    res_found_d  = res_found_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    out_found_d  = out_found_q;
    out_status_d = out_status_q;
    adj_re       = 1'b0;
    adj_raddr    = '0;
    adj_we       = 1'b0;
    adj_waddr    = '0;
    adj_wdata    = '0;
    stk_re       = 1'b0;
    stk_raddr    = '0;
    stk_we       = 1'b0;
    stk_waddr    = '0;
    stk_wdata    = '0;

    // Register writes; keep them to times when no item is in flight
    if (cfg_we_i) begin
      if (cfg_idx_i == dgcd_pkg::CfgVertexCount) begin
        n_d = cfg_n;
        for (int i = 0; i < MaxV; i++) begin
          keep_d[i] = (32'(i) < 32'(cfg_n));
        end
      end else begin
        mirror_d = cfg_wdata_i[0];
      end
    end

    case (state_q)
      dgcd_pkg::SIdle: begin
        if (s_accept) begin
          res_found_d = 1'b0;
          from_d      = VtxW'(s_from);
          to_d        = VtxW'(s_to);
          case (s_action)
            dgcd_pkg::ActAddEdge: begin
              res_status_d = s_out_of_range ? dgcd_pkg::StRangeErr : dgcd_pkg::StEdgeStored;
              adj_re       = !s_out_of_range;
              adj_raddr    = VtxW'(s_from);
            end
            dgcd_pkg::ActCheck: begin
              res_status_d = dgcd_pkg::StCheckDone;
              visited_d    = '0;
              onpath_d     = '0;
              root_d       = '0;
              sp_d         = '0;
            end
            dgcd_pkg::ActClear: begin
              res_status_d = dgcd_pkg::StCleared;
              row_valid_d  = '0;
            end
            default: begin
              res_status_d = dgcd_pkg::StRangeErr;
            end
          endcase
        end
      end
      // Merge the new bit into the fetched row and write it back
      dgcd_pkg::SAddWr1: begin
        adj_we                 = 1'b1;
        adj_waddr              = from_q;
        adj_wdata              = cur_row | (dgcd_pkg::row_t'(1) << to_q);
        row_valid_d[from_q]    = 1'b1;
      end
      dgcd_pkg::SAddRd2: begin
        adj_re    = 1'b1;
        adj_raddr = to_q;
      end
      dgcd_pkg::SAddWr2: begin
        adj_we               = 1'b1;
        adj_waddr            = to_q;
        adj_wdata            = cur_row | (dgcd_pkg::row_t'(1) << from_q);
        row_valid_d[to_q]    = 1'b1;
      end
      // Start a walk from the next unvisited root, or finish once every root is tried
      dgcd_pkg::SCkRoot: begin
        if (root_q >= n_q) begin
          res_found_d = 1'b0;
        end else if (visited_q[root_q[VtxW-1:0]]) begin
          root_d = root_q + CntW'(1);
        end else begin
          visited_d[root_q[VtxW-1:0]] = 1'b1;
          onpath_d[root_q[VtxW-1:0]]  = 1'b1;
          top_vtx_d = root_q[VtxW-1:0];
          top_idx_d = '0;
          sp_d      = CntW'(1);
          adj_re    = 1'b1;
          adj_raddr = root_q[VtxW-1:0];
        end
      end
      dgcd_pkg::SCkLoad: begin
        row_d = cur_row & keep_q;
      end
      // Advance to the next neighbor, descend, backtrack, or stop on a found cycle
      dgcd_pkg::SCkStep: begin
        if (!nb_found) begin
          onpath_d[top_vtx_q] = 1'b0;
          sp_d                = sp_q - CntW'(1);
          if (sp_q == CntW'(1)) begin
            root_d = root_q + CntW'(1);
          end else begin
            stk_re    = 1'b1;
            stk_raddr = VtxW'(sp_q - CntW'(2));
          end
        end else begin
          top_idx_d = nb_next_idx;
          if (!visited_q[nb_j]) begin
            visited_d[nb_j] = 1'b1;
            onpath_d[nb_j]  = 1'b1;
            if (32'(sp_q) < MaxV) begin
              stk_we        = 1'b1;
              stk_waddr     = VtxW'(sp_q - CntW'(1));
              stk_wdata.idx = nb_next_idx;
              stk_wdata.vtx = top_vtx_q;
              top_vtx_d     = nb_j;
              top_idx_d     = '0;
              sp_d          = sp_q + CntW'(1);
              adj_re        = 1'b1;
              adj_raddr     = nb_j;
            end
          end else if (onpath_q[nb_j]) begin
            res_found_d = 1'b1;
          end
        end
      end
      // Restore the popped entry as top of stack and refetch its row
      dgcd_pkg::SCkPop: begin
        top_vtx_d = stk_rdata_q.vtx;
        top_idx_d = stk_rdata_q.idx;
        adj_re    = 1'b1;
        adj_raddr = stk_rdata_q.vtx;
      end
      default: ;
    endcase

    // Output register
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_found_d  = res_found_q;
      out_status_d = res_status_q;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and walk registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= dgcd_pkg::SIdle;
      n_q          <= CntW'(MaxV);
      keep_q       <= '1;
      mirror_q     <= 1'b0;
      row_valid_q  <= '0;
      from_q       <= '0;
      to_q         <= '0;
      visited_q    <= '0;
      onpath_q     <= '0;
      root_q       <= '0;
      sp_q         <= '0;
      top_vtx_q    <= '0;
      top_idx_q    <= '0;
      row_q        <= '0;
      res_found_q  <= 1'b0;
      res_status_q <= dgcd_pkg::StEdgeStored;
      out_valid_q  <= 1'b0;
      out_found_q  <= 1'b0;
      out_status_q <= dgcd_pkg::StEdgeStored;
    end else begin
      state_q      <= state_d;
      n_q          <= n_d;
      keep_q       <= keep_d;
      mirror_q     <= mirror_d;
      row_valid_q  <= row_valid_d;
      from_q       <= from_d;
      to_q         <= to_d;
      visited_q    <= visited_d;
      onpath_q     <= onpath_d;
      root_q       <= root_d;
      sp_q         <= sp_d;
      top_vtx_q    <= top_vtx_d;
      top_idx_q    <= top_idx_d;
      row_q        <= row_d;
      res_found_q  <= res_found_d;
      res_status_q <= res_status_d;
      out_valid_q  <= out_valid_d;
      out_found_q  <= out_found_d;
      out_status_q <= out_status_d;
    end
  end

  // Adjacency memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    if (adj_re) begin
      adj_rdata_q  <= adj_mem[adj_raddr];
      adj_rvalid_q <= row_valid_q[adj_raddr];
    end
  end

  // Walk stack memory
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata_q <= stk_mem[stk_raddr];
    end
  end

endmodule

>>> hw/rtl/dgcd_checker.sv
// ============================================================================
// dgcd_checker
// Port-level checks of the cycle detector, bound to the top level.
// ============================================================================
module dgcd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [dgcd_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [1:0]                    m_axis_tuser
);

  // A found cycle only comes with a check result
  a_found_only_on_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tuser == dgcd_pkg::StCheckDone)
    else $error("cycle_found set on a non-check result");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // An accepted item keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item taken right after another");

  // A new result only follows work in progress
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while idle");

endmodule

bind directed_graph_cycle_detect_unit dgcd_checker u_dgcd_checker (.*);

>>> bench/directed_graph_cycle_detect_unit_tb.sv
// ============================================================================
// directed_graph_cycle_detect_unit_tb
// Self-checking bench for the directed graph cycle detector. It loads edges,
// runs cycle checks and clears over several vertex counts and mirror
// settings. An in-bench graph model predicts every result. Both stream sides
// idle at random, and there is one long output hold-off.
// ============================================================================
module directed_graph_cycle_detect_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxVertices  = dgcd_pkg::MaxVertices;
  localparam int unsigned CfgW         = dgcd_pkg::CfgW;
  localparam int unsigned InDataW      = dgcd_pkg::InDataW;
  localparam int unsigned OutDataW     = dgcd_pkg::OutDataW;

  localparam int unsigned CycleLimit   = 3_000_000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned LongHold     = 300;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned RandomItems  = 400;

  typedef struct packed {
    logic       cycle_found;
    logic [1:0] status;
  } result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic                cfg_idx_i;
  logic [CfgW-1:0]     cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;

  directed_graph_cycle_detect_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // from_vertex[5:0], to_vertex[11:6]
    .s_axis_tuser  (s_axis_tuser),   // action[1:0]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // cycle_found[0]
    .m_axis_tuser  (m_axis_tuser)    // status[1:0]
  );

  // Graph model state and its copy of the registers
  dgcd_pkg::row_t  graph_rows [MaxVertices];
  logic [CfgW-1:0] vcount_reg;
  logic            mirror_reg;

  result_t     pending_results [$];
  result_t     expected_front;
  int unsigned error_count        = 0;
  int unsigned results_seen       = 0;
  int unsigned items_sent         = 0;
  int unsigned useful_items       = 0;
  int unsigned checks_run         = 0;
  int unsigned cycles_found       = 0;
  int unsigned range_errors       = 0;
  int unsigned input_stall_cycles = 0;
  int unsigned cycle_count        = 0;

  // Idling controls
  bit          tx_burst        = 1'b0;
  bit          rx_burst        = 1'b0;
  int unsigned rx_hold_request = 0;
  int unsigned rx_hold_left    = 0;
  int unsigned rx_stall_left   = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still expected", cycle_count,
             pending_results.size());
    $display("directed_graph_cycle_detect_unit_tb: FAIL");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned random_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // Any vertex number the field can carry
  function automatic dgcd_pkg::vtx_t rand_vtx();
    return dgcd_pkg::vtx_t'($urandom_range(0, 63));
  endfunction

  // Vertex count as the block applies it: saturated to 1..MaxVertices
  function automatic int unsigned active_vertices();
    if (vcount_reg == 0) return 1;
    if (32'(vcount_reg) > MaxVertices) return MaxVertices;
    return 32'(vcount_reg);
  endfunction

  // Iterative depth-first walk over the vertices in use; stop at the first
  // edge that lands on a vertex of the current path
  function automatic logic graph_has_cycle();
    int unsigned    n, root, top, v, j, depth;
    int unsigned    walk_vtx  [MaxVertices];
    int unsigned    walk_next [MaxVertices];
    dgcd_pkg::row_t keep, seen, on_path, row;
    n       = active_vertices();
    keep    = {MaxVertices{1'b1}};
    if (n < MaxVertices) keep = (dgcd_pkg::row_t'(1) << n) - dgcd_pkg::row_t'(1);
    seen    = '0;
    on_path = '0;
    for (root = 0; root < n; root++) begin
      if (seen[root]) continue;
      seen[root]    = 1'b1;
      on_path[root] = 1'b1;
      walk_vtx[0]   = root;
      walk_next[0]  = 0;
      depth         = 1;
      while (depth > 0) begin
        top = depth - 1;
        v   = walk_vtx[top];
        row = graph_rows[v] & keep;
        j   = MaxVertices;
        for (int k = walk_next[top]; k < MaxVertices; k++) begin
          if (row[k]) begin
            j = k;
            break;
          end
        end
        if (j == MaxVertices) begin
          // no neighbor left: backtrack
          on_path[v] = 1'b0;
          depth--;
        end else begin
          walk_next[top] = j + 1;
          if (!seen[j]) begin
            seen[j]    = 1'b1;
            on_path[j] = 1'b1;
            if (depth < MaxVertices) begin
              walk_vtx[depth]  = j;
              walk_next[depth] = 0;
              depth++;
            end
          end else if (on_path[j]) begin
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  // Apply one accepted item to the graph model and return its result
  function automatic result_t predict_result(input dgcd_pkg::action_e act,
                                             input dgcd_pkg::vtx_t src,
                                             input dgcd_pkg::vtx_t dst);
    result_t     r;
    int unsigned n;
    n             = active_vertices();
    r.cycle_found = 1'b0;
    r.status      = dgcd_pkg::StRangeErr;
    case (act)
      dgcd_pkg::ActAddEdge: begin
        if (src < n && dst < n) begin
          graph_rows[src][dst] = 1'b1;
          if (mirror_reg) graph_rows[dst][src] = 1'b1;
          r.status = dgcd_pkg::StEdgeStored;
        end
      end
      dgcd_pkg::ActCheck: begin
        r.cycle_found = graph_has_cycle();
        r.status      = dgcd_pkg::StCheckDone;
        checks_run++;
        if (r.cycle_found) cycles_found++;
      end
      dgcd_pkg::ActClear: begin
        foreach (graph_rows[i]) graph_rows[i] = '0;
        r.status = dgcd_pkg::StCleared;
      end
      default: ;
    endcase
    if (r.status == dgcd_pkg::StRangeErr) range_errors++;
    return r;
  endfunction

  // Offer one item, hold it until accepted, then record its expected result
  task automatic send_item(input dgcd_pkg::action_e act, input dgcd_pkg::vtx_t src,
                           input dgcd_pkg::vtx_t dst);
    int unsigned gap;
    result_t     expected;
    gap = tx_burst ? 0 : random_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = act;
    s_axis_tdata  = {4'b0, dst, src};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected = predict_result(act, src, dst);
    pending_results.insert(pending_results.size(), expected);
    items_sent++;
    if (act != dgcd_pkg::ActNone) useful_items++;
  endtask

  // Stop offering and wait until every expected result is in
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input dgcd_pkg::cfg_reg_e idx, input logic [CfgW-1:0] value);
    drain_results();
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == dgcd_pkg::CfgVertexCount) vcount_reg = value;
    else mirror_reg = value[0];
  endtask

  task automatic set_random_config();
    logic [CfgW-1:0] count, wdata;
    int unsigned     pick;
    pick = $urandom_range(0, 99);
    if (pick < 60)      count = CfgW'($urandom_range(2, 12));
    else if (pick < 75) count = CfgW'($urandom_range(13, 63));
    else if (pick < 85) count = CfgW'(MaxVertices);
    else if (pick < 90) count = CfgW'(1);
    else if (pick < 95) count = '0;
    else                count = CfgW'($urandom_range(65, 127));
    write_reg(dgcd_pkg::CfgVertexCount, count);
    // upper bits of the mirror write are don't-care
    wdata    = CfgW'($urandom_range(0, 127));
    wdata[0] = ($urandom_range(0, 3) == 0);
    write_reg(dgcd_pkg::CfgMirrorEdges, wdata);
  endtask

  // Mostly forward edges (acyclic), some arbitrary ones that may close a
  // cycle, rare self loops, plus out-of-range and unused-action noise
  task automatic send_random_edge();
    int unsigned    n, pick;
    dgcd_pkg::vtx_t src, dst;
    n    = active_vertices();
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      src = '0;
      dst = '0;
      if (n >= 2) begin
        src = dgcd_pkg::vtx_t'($urandom_range(0, n - 2));
        dst = dgcd_pkg::vtx_t'($urandom_range(32'(src) + 1, n - 1));
      end
      send_item(dgcd_pkg::ActAddEdge, src, dst);
    end else if (pick < 80) begin
      src = dgcd_pkg::vtx_t'($urandom_range(0, n - 1));
      dst = dgcd_pkg::vtx_t'($urandom_range(0, n - 1));
      send_item(dgcd_pkg::ActAddEdge, src, dst);
    end else if (pick < 82) begin
      src = dgcd_pkg::vtx_t'($urandom_range(0, n - 1));
      send_item(dgcd_pkg::ActAddEdge, src, src);
    end else if (pick < 94) begin
      send_item(dgcd_pkg::ActAddEdge, rand_vtx(), rand_vtx());
    end else begin
      send_item(dgcd_pkg::ActNone, rand_vtx(), rand_vtx());
    end
  endtask

  // Output side: random stalls, burst stretches and requested hold-offs
  always @(negedge clk_i) begin
    if (rx_hold_request != 0) begin
      rx_hold_left    = rx_hold_request;
      rx_hold_request = 0;
    end
    if (rx_hold_left != 0) begin
      m_axis_tready = 1'b0;
      rx_hold_left--;
    end else if (rx_burst) begin
      m_axis_tready = 1'b1;
    end else if (rx_stall_left != 0) begin
      m_axis_tready = 1'b0;
      rx_stall_left--;
    end else if ($urandom_range(0, 99) < 65) begin
      m_axis_tready = 1'b1;
    end else begin
      m_axis_tready = 1'b0;
      rx_stall_left = random_gap();
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && !s_axis_tready) input_stall_cycles++;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MaxReports)
          $display("result %0d with nothing expected: cycle_found=%0d status=%0d",
                   results_seen, m_axis_tdata[0], m_axis_tuser);
      end else begin
        expected_front = pending_results.pop_front();
        if (m_axis_tdata !== {{(OutDataW-1){1'b0}}, expected_front.cycle_found} ||
            m_axis_tuser !== expected_front.status) begin
          error_count++;
          if (error_count <= MaxReports)
            $display({"result %0d mismatch: expected cycle_found=%0d status=%0d, ",
                      "got tdata=%h status=%0d"},
                     results_seen, expected_front.cycle_found, expected_front.status,
                     m_axis_tdata, m_axis_tuser);
        end
      end
    end
  end

  // Extreme endpoints, duplicate edge, self loop, clear, unused action
  task automatic test_edges_and_extremes();
    send_item(dgcd_pkg::ActCheck, 6'd0, 6'd0);
    send_item(dgcd_pkg::ActAddEdge, 6'd0, 6'd63);
    send_item(dgcd_pkg::ActAddEdge, 6'd63, 6'd0);
    send_item(dgcd_pkg::ActAddEdge, 6'd0, 6'd63);
    send_item(dgcd_pkg::ActCheck, 6'd0, 6'd0);
    send_item(dgcd_pkg::ActClear, 6'd63, 6'd63);
    send_item(dgcd_pkg::ActCheck, 6'd0, 6'd0);
    send_item(dgcd_pkg::ActAddEdge, 6'd5, 6'd5);
    send_item(dgcd_pkg::ActCheck, 6'd0, 6'd0);
    send_item(dgcd_pkg::ActNone, 6'd63, 6'd63);
  endtask

  // Endpoints at and above the count; a zero count acts as one vertex;
  // counts above the maximum saturate
  task automatic test_vertex_range();
    write_reg(dgcd_pkg::CfgVertexCount, 7'd8);
    send_item(dgcd_pkg::ActAddEdge, 6'd8, 6'd1);
    send_item(dgcd_pkg::ActAddEdge, 6'd1, 6'd8);
    send_item(dgcd_pkg::ActAddEdge, 6'd7, 6'd0);
    write_reg(dgcd_pkg::CfgVertexCount, 7'd0);
    send_item(dgcd_pkg::ActAddEdge, 6'd0, 6'd0);
    send_item(dgcd_pkg::ActAddEdge, 6'd0, 6'd1);
    send_item(dgcd_pkg::ActCheck, 6'd0, 6'd0);
    send_item(dgcd_pkg::ActClear, 6'd0, 6'd0);
    write_reg(dgcd_pkg::CfgVertexCount, 7'd127);
    send_item(dgcd_pkg::ActAddEdge, 6'd63, 6'd62);
    send_item(dgcd_pkg::ActCheck, 6'd0, 6'd0);
  endtask

  // A cycle through a vertex beyond a shrunken count must be ignored
  task automatic test_stale_edges();
    send_item(dgcd_pkg::ActAddEdge, 6'd2, 6'd40);
    send_item(dgcd_pkg::ActAddEdge, 6'd40, 6'd2);
    write_reg(dgcd_pkg::CfgVertexCount, 7'd8);
    send_item(dgcd_pkg::ActCheck, 6'd0, 6'd0);
    write_reg(dgcd_pkg::CfgVertexCount, 7'd64);
    send_item(dgcd_pkg::ActCheck, 6'd0, 6'd0);
  endtask

  // In mirror mode one edge already makes a two-vertex cycle
  task automatic test_mirror_mode();
    write_reg(dgcd_pkg::CfgMirrorEdges, 7'h7f);
    send_item(dgcd_pkg::ActClear, 6'd0, 6'd0);
    send_item(dgcd_pkg::ActAddEdge, 6'd3, 6'd4);
    send_item(dgcd_pkg::ActCheck, 6'd0, 6'd0);
  endtask

  // Hold the output off while items keep coming back to back, so the block
  // fills and stalls its input
  task automatic test_output_backpressure();
    write_reg(dgcd_pkg::CfgVertexCount, 7'd64);
    write_reg(dgcd_pkg::CfgMirrorEdges, 7'd0);
    send_item(dgcd_pkg::ActClear, 6'd0, 6'd0);
    tx_burst        = 1'b1;
    rx_hold_request = LongHold;
    for (int i = 0; i < 40; i++) begin
      send_item(dgcd_pkg::ActAddEdge, dgcd_pkg::vtx_t'(i), dgcd_pkg::vtx_t'(i + 1));
    end
    send_item(dgcd_pkg::ActCheck, 6'd0, 6'd0);
    send_item(dgcd_pkg::ActAddEdge, 6'd40, 6'd0);
    send_item(dgcd_pkg::ActCheck, 6'd0, 6'd0);
    tx_burst = 1'b0;
    drain_results();
  endtask

  // Phases of random settings; each builds graphs, mostly from a clear, and checks them
  task automatic test_random_graphs(input int unsigned target);
    int unsigned start, rounds, edges;
    start = useful_items;
    while (useful_items - start < target) begin
      set_random_config();
      tx_burst = ($urandom_range(0, 5) == 0);
      rx_burst = ($urandom_range(0, 5) == 0);
      rounds   = $urandom_range(1, 4);
      repeat (rounds) begin
        if ($urandom_range(0, 3) != 0)
          send_item(dgcd_pkg::ActClear, rand_vtx(), rand_vtx());
        edges = $urandom_range(2, 14);
        repeat (edges) begin
          send_random_edge();
          if ($urandom_range(0, 9) == 0)
            send_item(dgcd_pkg::ActCheck, rand_vtx(), rand_vtx());
        end
        send_item(dgcd_pkg::ActCheck, rand_vtx(), rand_vtx());
      end
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = dgcd_pkg::CfgVertexCount;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    vcount_reg    = CfgW'(MaxVertices);
    mirror_reg    = 1'b0;
    foreach (graph_rows[i]) graph_rows[i] = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_edges_and_extremes();
    test_vertex_range();
    test_stale_edges();
    test_mirror_mode();
    test_output_backpressure();
    test_random_graphs(RandomItems);

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    $display("covered %0d items (%0d checks, %0d with a cycle, %0d range errors), %0d results",
             items_sent, checks_run, cycles_found, range_errors, results_seen);
    $display("input stalled for %0d cycles; %0d mismatches", input_stall_cycles, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("directed_graph_cycle_detect_unit_tb: PASS");
    end else begin
      $display("directed_graph_cycle_detect_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> directed_graph_cycle_detect_unit.f
hw/rtl/dgcd_pkg.sv
hw/rtl/directed_graph_cycle_detect_unit.sv
hw/rtl/dgcd_checker.sv
bench/directed_graph_cycle_detect_unit_tb.sv
